@@ sv/rmed_pkg.sv @@
// shared types and constants for the multichannel running median block
// no dependencies; imported by every other module of the block except rmed_ram

package rmed_pkg;

	localparam int CHAN_W   = 3;
	localparam int SAMPLE_W = 8;
	localparam int TDATA_W  = 16;
	localparam int PAD_W    = TDATA_W - CHAN_W - SAMPLE_W;

	// value travelling along the sorting chain
	typedef struct packed {
		logic                vld;
		logic [SAMPLE_W-1:0] data;
	} rmed_link_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SORT,
		ST_RESULT
	} rmed_state_t;

endpackage

@@ sv/rmed_ram.sv @@
// generic single-write, single-read ram with registered read data
// no package dependency

module rmed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/rmed_cell.sv @@
// one cell of the systolic insertion sorter: keeps the smallest value seen,
// forwards the larger one to its right neighbor; depends on rmed_pkg

module rmed_cell import rmed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  rmed_link_t in,
	output rmed_link_t fwd,
	output rmed_link_t held
);

	logic                held_vld_q;
	logic [SAMPLE_W-1:0] held_data_q;
	logic                fwd_vld_q;
	logic [SAMPLE_W-1:0] fwd_data_q;
	logic                take_in;

	assign take_in = !held_vld_q || (in.data < held_data_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			fwd_vld_q  <= 1'b0;
		end else if (clear) begin
			held_vld_q <= 1'b0;
			fwd_vld_q  <= 1'b0;
		end else begin
			fwd_vld_q <= in.vld && held_vld_q;
			if (in.vld) begin
				held_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in.vld) begin
			if (take_in) begin
				held_data_q <= in.data;
				fwd_data_q  <= held_data_q;
			end else begin
				fwd_data_q  <= in.data;
			end
		end
	end

	assign fwd  = '{vld: fwd_vld_q, data: fwd_data_q};
	assign held = '{vld: held_vld_q, data: held_data_q};

endmodule

@@ sv/multichannel_running_median.sv @@
// a known channel passes the load state (ram write-back), the sort state and the result
// state; the sort state feeds the cell chain one sample per cycle and lets it settle, and
// the result state waits for the output register to free up; one item is in work at a time
// an unknown channel skips the ram and the chain and goes straight to the result state;
// the input is free again as soon as its result is offered
// reset: per-channel valid bits clear at once, so every window reads as zeros
// and every write pointer as slot zero; no clearing pass is needed
// depends on rmed_pkg, rmed_ram, rmed_cell

module multichannel_running_median import rmed_pkg::*; #(
	parameter int CHANNELS = 8,
	parameter int WINDOW   = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // channel [2:0], sample [10:3], zero pad
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata   // channel_out [2:0], median [10:3], zero pad
);

	// ram row per channel: WINDOW samples as a ring, plus the write pointer on top
	localparam int AW        = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int PTR_W     = WINDOW > 1 ? $clog2(WINDOW) : 1;
	localparam int ROW_W     = WINDOW * SAMPLE_W + PTR_W;
	localparam int CNT_W     = $clog2(2 * WINDOW);
	localparam int MID       = WINDOW / 2;
	localparam int SORT_LAST = 2 * WINDOW - 2;

	rmed_state_t         state_q, state_d;
	logic [CHAN_W-1:0]   chan_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                bad_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] row_q [WINDOW];
	logic                vld_q [CHANNELS];
	logic                m_valid_q;
	logic [TDATA_W-1:0]  m_data_q;

	logic                s_fire;
	logic [CHAN_W-1:0]   in_chan;
	logic [SAMPLE_W-1:0] in_sample;
	logic                in_bad;
	logic [AW-1:0]       addr_q;
	logic [ROW_W-1:0]    rd_row;
	logic [ROW_W-1:0]    new_row;
	logic                row_vld;
	logic [PTR_W-1:0]    cur_ptr;
	logic [PTR_W-1:0]    nxt_ptr;
	logic [SAMPLE_W-1:0] new_slot [WINDOW];
	logic                out_load;
	logic [SAMPLE_W-1:0] median_sel;

	rmed_link_t          link [WINDOW+1];
	rmed_link_t          held_v [WINDOW];

	// input side
	assign in_chan       = s_axis_tdata[CHAN_W-1:0];
	assign in_sample     = s_axis_tdata[CHAN_W +: SAMPLE_W];
	assign in_bad        = 32'(in_chan) >= CHANNELS;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign addr_q        = AW'(chan_q);

	// window store, read on the accepting transfer, written back in the load state that follows it
	rmed_ram #(
		.WIDTH(ROW_W),
		.DEPTH(CHANNELS)
	) u_store (
		.clk   (clk),
		.we    (state_q == ST_LOAD),
		.waddr (addr_q),
		.wdata (new_row),
		.re    (s_fire && !in_bad),
		.raddr (AW'(in_chan)),
		.rdata (rd_row)
	);

	// a row never written reads as all zeros with pointer zero
	always_comb begin
		row_vld = vld_q[addr_q];
		cur_ptr = row_vld ? rd_row[ROW_W-1 -: PTR_W] : '0;
		nxt_ptr = (cur_ptr == PTR_W'(WINDOW - 1)) ? '0 : cur_ptr + 1'b1;
		for (int i = 0; i < WINDOW; i++) begin
			if (cur_ptr == PTR_W'(i)) begin
				new_slot[i] = sample_q;
			end else if (row_vld) begin
				new_slot[i] = rd_row[i*SAMPLE_W +: SAMPLE_W];
			end else begin
				new_slot[i] = '0;
			end
			new_row[i*SAMPLE_W +: SAMPLE_W] = new_slot[i];
		end
		new_row[ROW_W-1 -: PTR_W] = nxt_ptr;
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					state_d = in_bad ? ST_RESULT : ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_SORT;
			end
			ST_SORT: begin
				if (cnt_q == CNT_W'(SORT_LAST)) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				// wait for the output register to free up
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			bad_q     <= 1'b0;
			m_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				vld_q[c] <= 1'b0;
			end
		end else begin
			if (s_fire) begin
				bad_q <= in_bad;
			end
			if (state_q == ST_LOAD) begin
				cnt_q         <= '0;
				vld_q[addr_q] <= 1'b1;
			end else if (state_q == ST_SORT) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			chan_q   <= in_chan;
			sample_q <= in_sample;
		end
		if (state_q == ST_LOAD) begin
			row_q <= new_slot;
		end
		if (out_load) begin
			m_data_q <= {{PAD_W{1'b0}}, median_sel, chan_q};
		end
	end

	// feed the updated window into the chain, slot zero first, one per cycle
	always_comb begin
		link[0].vld  = (state_q == ST_SORT) && (cnt_q < CNT_W'(WINDOW));
		link[0].data = link[0].vld ? row_q[cnt_q[PTR_W-1:0]] : '0;
	end

	// sorting chain: after settling, cell k holds the k-th smallest sample
	for (genvar k = 0; k < WINDOW; k++) begin : g_cell
		rmed_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clear  (state_q == ST_LOAD),
			.in     (link[k]),
			.fwd    (link[k+1]),
			.held   (held_v[k])
		);
	end

	assign median_sel    = bad_q ? '0 : held_v[MID].data;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef ASSERT_OFF
	// a known channel always goes through the ram update
	a_known_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !in_bad |=> state_q == ST_LOAD)
		else $error("accepted channel did not start a window update");

	// the chain is as long as the window, so nothing ever falls off its end
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!link[WINDOW].vld)
		else $error("sorting chain overflowed");

	// the median cell is filled by the time a result is formed
	a_mid_filled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESULT && !bad_q |-> held_v[MID].vld)
		else $error("median cell empty at result time");

	// a new result only comes out of the result state
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_RESULT)
		else $error("result offered outside the result state");
`endif

endmodule

@@ verif/multichannel_running_median_tb.sv @@
// self-checking testbench for multichannel_running_median: random stream traffic both sides
// predicts each channel's window median in its own model; depends on rmed_pkg and the block rtl

module multichannel_running_median_tb;
	import rmed_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH       = 8;
	localparam int WIN          = 5;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int LONG_HOLD_AT = 300;   // medians seen before the long output stall
	localparam int LONG_HOLD    = 400;   // cycles of that stall
	localparam int QUIET_ITEMS  = 200;   // final stretch with no idling on either side
	localparam int TAIL_CYCLES  = 40;

	// one pending sample transfer, or a marker that pauses the sender until all medians are in
	typedef struct {
		logic                drain;
		logic [CHAN_W-1:0]   ch;
		logic [SAMPLE_W-1:0] smp;
	} sample_item_t;

	typedef struct {
		logic [CHAN_W-1:0]   ch;
		logic [SAMPLE_W-1:0] med;
	} median_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata  = '0;   // channel [2:0], sample [10:3], zero pad
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;         // channel_out [2:0], median [10:3], zero pad

	sample_item_t samples_q[$];
	median_t      medians_q[$];
	sample_item_t cur_item;

	// model state: each channel's ring of samples and its write slot
	logic [SAMPLE_W-1:0] ring_mem[NUM_CH][WIN];
	int                  ring_slot[NUM_CH];

	int n_total        = 0;
	int n_sent         = 0;
	int n_medians      = 0;
	int n_errors       = 0;
	int n_pauses       = 0;
	int n_cycles       = 0;
	int quiet_from     = 0;
	int send_gap       = 0;
	int recv_hold      = 0;
	bit long_hold_done = 1'b0;

	multichannel_running_median #(
		.CHANNELS(NUM_CH),
		.WINDOW  (WIN)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #6 clk = ~clk;

	// write the sample into the channel's ring, then rank a copy of the ring
	function automatic median_t insert_and_rank(sample_item_t it);
		median_t             res;
		logic [SAMPLE_W-1:0] sorted[WIN];
		logic [SAMPLE_W-1:0] v;
		int                  slot;
		int                  j;
		res.ch  = it.ch;
		res.med = '0;
		// channels beyond the configured count leave the state alone and report zero
		if (it.ch >= NUM_CH)
			return res;
		slot = (ring_slot[it.ch] >= WIN) ? 0 : ring_slot[it.ch];
		ring_mem[it.ch][slot] = it.smp;
		ring_slot[it.ch] = (slot + 1 >= WIN) ? 0 : slot + 1;
		for (int i = 0; i < WIN; i++)
			sorted[i] = ring_mem[it.ch][i];
		// insertion sort, ascending
		for (int i = 1; i < WIN; i++) begin
			v = sorted[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		res.med = sorted[WIN/2];
		return res;
	endfunction

	// distance values weighted toward the extremes and toward clusters that make ties
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return SAMPLE_W'($urandom_range(0, 3));
			3:       return SAMPLE_W'($urandom_range(120, 135));
			default: return SAMPLE_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic queue_sample(input int ch, input int smp);
		sample_item_t it;
		it.drain = 1'b0;
		it.ch    = CHAN_W'(ch);
		it.smp   = SAMPLE_W'(smp);
		samples_q.push_back(it);
		n_total++;
	endtask

	task automatic queue_pause();
		sample_item_t it;
		it.drain = 1'b1;
		it.ch    = '0;
		it.smp   = '0;
		samples_q.push_back(it);
	endtask

	// sender: one transfer offered at a time, held until accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			// accepted transfer: predict its median now, in acceptance order
			if (s_axis_tvalid && s_axis_tready) begin
				medians_q.push_back(insert_and_rank(cur_item));
				n_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (samples_q.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (samples_q[0].drain) begin
					// pause until the block has handed back every median
					s_axis_tvalid <= 1'b0;
					if (medians_q.size() == 0) begin
						void'(samples_q.pop_front());
						n_pauses++;
					end
				end else if (n_sent < quiet_from && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(1, 19) - 1;
					s_axis_tvalid <= 1'b0;
				end else begin
					cur_item = samples_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {{PAD_W{1'b0}}, cur_item.smp, cur_item.ch};
				end
			end
		end
	end

	// receiver: checks each median transfer against the oldest prediction
	always @(posedge clk) begin
		median_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_hold = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				n_medians++;
				if (medians_q.size() == 0) begin
					$error("median transfer with nothing expected: tdata 0x%h", m_axis_tdata);
					n_errors++;
				end else begin
					want = medians_q.pop_front();
					if (m_axis_tdata[CHAN_W-1:0] !== want.ch) begin
						$error("channel_out: expected %0d, got %0d",
							want.ch, m_axis_tdata[CHAN_W-1:0]);
						n_errors++;
					end
					if (m_axis_tdata[CHAN_W +: SAMPLE_W] !== want.med) begin
						$error("median: expected %0d, got %0d",
							want.med, m_axis_tdata[CHAN_W +: SAMPLE_W]);
						n_errors++;
					end
					if (m_axis_tdata[TDATA_W-1:CHAN_W+SAMPLE_W] !== '0) begin
						$error("pad: expected 0, got 0x%h",
							m_axis_tdata[TDATA_W-1:CHAN_W+SAMPLE_W]);
						n_errors++;
					end
				end
			end
			// one long stall so the block fills up and pushes back on the sender
			if (!long_hold_done && n_medians >= LONG_HOLD_AT) begin
				recv_hold = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				m_axis_tready <= 1'b0;
			end else if (n_medians < quiet_from && $urandom_range(0, 7) == 0) begin
				recv_hold = $urandom_range(1, 19) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("multichannel_running_median_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int ch;
		int burst;
		for (int c = 0; c < NUM_CH; c++) begin
			ring_slot[c] = 0;
			for (int i = 0; i < WIN; i++)
				ring_mem[c][i] = '0;
		end

		// fresh window: zeros from reset outvote the first two full-scale samples
		queue_sample(0, 255);
		queue_sample(0, 255);
		queue_sample(0, 255);
		// extremes and midscale on the top channel
		queue_sample(7, 0);
		queue_sample(7, 128);
		queue_sample(7, 1);
		// equal samples fill the whole window, then one outlier
		for (int i = 0; i < WIN; i++)
			queue_sample(3, 85);
		queue_sample(3, 170);
		// ring wraps on channel 0 and pushes out the oldest full-scale value
		queue_sample(0, 0);
		queue_sample(0, 0);
		queue_sample(0, 1);
		// every other channel once at full scale
		for (int c = 1; c < NUM_CH - 1; c++)
			if (c != 3)
				queue_sample(c, 255);
		queue_pause();

		// random part: mostly bursts on one channel so windows turn over completely
		while (n_total < 1550) begin
			if (n_total >= 800 && n_pauses == 0 && samples_q[$].drain == 1'b0 &&
			    n_total < 810)
				queue_pause();
			ch = $urandom_range(0, NUM_CH - 1);
			if ($urandom_range(0, 9) < 7) begin
				burst = $urandom_range(1, 2 * WIN);
				for (int i = 0; i < burst; i++)
					queue_sample(ch, pick_sample());
			end else begin
				queue_sample(ch, pick_sample());
			end
		end
		quiet_from = n_total - QUIET_ITEMS;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (n_sent < n_total)
			@(posedge clk);
		while (medians_q.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d samples on %0d channels, %0d medians checked,",
			n_total, NUM_CH, n_medians);
		$display("with a long output stall and %0d sender pauses to empty the block", n_pauses);
		if (n_errors == 0 && medians_q.size() == 0) begin
			$display("multichannel_running_median_tb: PASS");
		end else begin
			$display("multichannel_running_median_tb: FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/rmed_pkg.sv
sv/rmed_ram.sv
sv/rmed_cell.sv
sv/multichannel_running_median.sv
verif/multichannel_running_median_tb.sv
